// ===== src/pgt_pkg.sv =====
// ----------------------------------------------------------------------------
// pgt_pkg
// Shared sizes, types and controller states of the pair grouping table.
// ----------------------------------------------------------------------------
package pgt_pkg;

	localparam int MAX_MEMBERS = 256;
	localparam int MAX_GROUPS  = 128;
	localparam int ID_BITS     = 16;

	localparam int MIDX_BITS = $clog2(MAX_MEMBERS);
	localparam int MCNT_BITS = $clog2(MAX_MEMBERS + 1);
	localparam int GIDX_BITS = $clog2(MAX_GROUPS);
	localparam int GCNT_BITS = $clog2(MAX_GROUPS + 1);

	typedef struct packed {
		logic [GIDX_BITS-1:0] grp;
		logic [ID_BITS-1:0]   id;
	} member_t;

	localparam int MEMBER_BITS = $bits(member_t);

	typedef struct packed {
		logic                 found;
		logic [GIDX_BITS-1:0] best;
		logic                 a_in;
	} match_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LEAD,
		ST_LWAIT,
		ST_NEW1,
		ST_NEW2,
		ST_DONE
	} state_t;

endpackage

// ===== src/pgt_ram.sv =====
// ----------------------------------------------------------------------------
// pgt_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pgt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/pgt_match.sv =====
// ----------------------------------------------------------------------------
// pgt_match
// Tracks the lowest group that holds either id of the pair during the scan.
// ----------------------------------------------------------------------------
module pgt_match (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          clear,
	input  logic                          hit_valid,
	input  pgt_pkg::member_t              member,
	input  logic [pgt_pkg::ID_BITS-1:0]   a,
	input  logic [pgt_pkg::ID_BITS-1:0]   b,
	output pgt_pkg::match_t               match
);

	pgt_pkg::match_t match_q;
	logic            is_a;
	logic            is_b;

	assign is_a  = member.id == a;
	assign is_b  = member.id == b;
	assign match = match_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= '0;
		end else if (clear) begin
			match_q <= '0;
		end else if (hit_valid && (is_a || is_b)) begin
			if (!match_q.found || member.grp < match_q.best) begin
				match_q.found <= 1'b1;
				match_q.best  <= member.grp;
				match_q.a_in  <= is_a;
			end else if (member.grp == match_q.best && is_a) begin
				match_q.a_in <= 1'b1;
			end
		end
	end

endmodule

// ===== src/pair_grouping_table.sv =====
// ----------------------------------------------------------------------------
// pair_grouping_table
// Groups linked id pairs under a leader; one result word per input word.
// ----------------------------------------------------------------------------
// Each pair walks the member store once, one read per cycle in store order.
// It then waits for the last read to land and closes the scan, does the
// leader lookup (LEAD, LWAIT) or the new group writes (NEW1, NEW2), none
// when a group start is dropped, hands off the result in DONE, where it
// waits while the output register is still full, and then takes in the next
// word in IDLE. The scan is paced by the single read port. A finished result
// sits in the output register while the next pair is taken in.
// ----------------------------------------------------------------------------
module pair_grouping_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // first_id[15:0], second_id[31:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata   // leader_id[15:0], removed_id[31:16],
	                              // group_index[38:32], started_group[39],
	                              // leader_conflict[40], table_full[41],
	                              // reduced_count[50:42], zero[55:51]
);

	localparam int IDB  = pgt_pkg::ID_BITS;
	localparam int MCB  = pgt_pkg::MCNT_BITS;
	localparam int GCB  = pgt_pkg::GCNT_BITS;
	localparam int GIB  = pgt_pkg::GIDX_BITS;
	localparam int MIB  = pgt_pkg::MIDX_BITS;

	pgt_pkg::state_t  state_q, state_d;
	logic [IDB-1:0]   a_q, b_q;
	logic [MCB-1:0]   scan_q;
	logic             rd_valid_s1;
	logic [MCB-1:0]   member_total_q;
	logic [GCB-1:0]   group_total_q;

	logic [IDB-1:0]   leader_q, removed_q;
	logic [GIB-1:0]   gidx_q;
	logic             started_q, conflict_q, full_q;

	logic             m_tvalid_q;
	logic [55:0]      m_tdata_q;

	logic             accept;
	logic             issue;
	logic             scan_end;
	logic             member_room;
	logic             group_room;
	logic             out_free;

	logic             mem_we;
	pgt_pkg::member_t mem_wdata;
	pgt_pkg::member_t mem_rdata;
	logic             lead_we;
	logic [IDB-1:0]   lead_rdata;
	pgt_pkg::match_t  match;
	logic [MCB-1:0]   reduced;

	assign accept      = s_tvalid && s_tready;
	assign scan_end    = (scan_q == member_total_q) && !rd_valid_s1;
	assign member_room = member_total_q < MCB'(pgt_pkg::MAX_MEMBERS);
	assign group_room  = (group_total_q < GCB'(pgt_pkg::MAX_GROUPS)) &&
	                     (member_total_q <= MCB'(pgt_pkg::MAX_MEMBERS - 2));
	assign out_free    = !m_tvalid_q || m_tready;
	assign reduced     = member_total_q - MCB'(group_total_q);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	pgt_ram #(
		.WIDTH (pgt_pkg::MEMBER_BITS),
		.DEPTH (pgt_pkg::MAX_MEMBERS)
	) u_member_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (member_total_q[MIB-1:0]),
		.wdata (mem_wdata),
		.raddr (scan_q[MIB-1:0]),
		.rdata (mem_rdata)
	);

	pgt_ram #(
		.WIDTH (IDB),
		.DEPTH (pgt_pkg::MAX_GROUPS)
	) u_leader_ram (
		.clk   (clk),
		.we    (lead_we),
		.waddr (group_total_q[GIB-1:0]),
		.wdata (a_q),
		.raddr (match.best),
		.rdata (lead_rdata)
	);

	pgt_match u_match (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (accept),
		.hit_valid (rd_valid_s1),
		.member    (mem_rdata),
		.a         (a_q),
		.b         (b_q),
		.match     (match)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pgt_pkg::ST_IDLE: begin
				if (s_tvalid) state_d = pgt_pkg::ST_SCAN;
			end
			pgt_pkg::ST_SCAN: begin
				if (scan_end) begin
					if (match.found)     state_d = pgt_pkg::ST_LEAD;
					else if (group_room) state_d = pgt_pkg::ST_NEW1;
					else                 state_d = pgt_pkg::ST_DONE;
				end
			end
			pgt_pkg::ST_LEAD:  state_d = pgt_pkg::ST_LWAIT;
			pgt_pkg::ST_LWAIT: state_d = pgt_pkg::ST_DONE;
			pgt_pkg::ST_NEW1:  state_d = pgt_pkg::ST_NEW2;
			pgt_pkg::ST_NEW2:  state_d = pgt_pkg::ST_DONE;
			pgt_pkg::ST_DONE: begin
				if (out_free) state_d = pgt_pkg::ST_IDLE;
			end
			default: state_d = pgt_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		s_tready  = 1'b0;
		issue     = 1'b0;
		mem_we    = 1'b0;
		lead_we   = 1'b0;
		mem_wdata = '{grp: group_total_q[GIB-1:0], id: a_q};
		case (state_q)
			pgt_pkg::ST_IDLE: s_tready = 1'b1;
			pgt_pkg::ST_SCAN: issue = scan_q != member_total_q;
			pgt_pkg::ST_LWAIT: begin
				mem_we    = member_room;
				mem_wdata = '{grp: match.best, id: (match.a_in ? b_q : a_q)};
			end
			pgt_pkg::ST_NEW1: begin
				mem_we  = 1'b1;
				lead_we = 1'b1;
			end
			pgt_pkg::ST_NEW2: begin
				mem_we    = 1'b1;
				mem_wdata = '{grp: group_total_q[GIB-1:0], id: b_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= pgt_pkg::ST_IDLE;
			scan_q         <= '0;
			rd_valid_s1    <= 1'b0;
			member_total_q <= '0;
			group_total_q  <= '0;
			m_tvalid_q     <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_valid_s1 <= issue;
			if (accept) begin
				scan_q <= '0;
			end else if (issue) begin
				scan_q <= scan_q + MCB'(1);
			end
			if (mem_we) begin
				member_total_q <= member_total_q + MCB'(1);
			end
			if (state_q == pgt_pkg::ST_NEW2) begin
				group_total_q <= group_total_q + GCB'(1);
			end
			if (state_q == pgt_pkg::ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			a_q <= s_tdata[15:0];
			b_q <= s_tdata[31:16];
		end
		case (state_q)
			pgt_pkg::ST_SCAN: begin
				// defaults for a dropped group start
				leader_q   <= a_q;
				removed_q  <= b_q;
				gidx_q     <= '0;
				started_q  <= 1'b0;
				conflict_q <= 1'b0;
				full_q     <= 1'b1;
			end
			pgt_pkg::ST_LWAIT: begin
				leader_q   <= lead_rdata;
				gidx_q     <= match.best;
				full_q     <= !member_room;
				conflict_q <= (a_q != lead_rdata) && (b_q != lead_rdata);
				removed_q  <= (a_q != lead_rdata && b_q == lead_rdata) ? a_q : b_q;
			end
			pgt_pkg::ST_NEW1: begin
				gidx_q    <= group_total_q[GIB-1:0];
				started_q <= 1'b1;
				full_q    <= 1'b0;
			end
			default: ;
		endcase
		if (state_q == pgt_pkg::ST_DONE && out_free) begin
			m_tdata_q <= {5'b0, reduced, full_q, conflict_q, started_q,
			              gidx_q, removed_q, leader_q};
		end
	end

endmodule

// ===== tb/pair_grouping_checker.sv =====
// ----------------------------------------------------------------------------
// pair_grouping_checker
// Watches both stream ports of the pair grouping table, keeps its own copy of
// the member and group stores, predicts one result word per accepted pair and
// compares every field of each result word against the oldest prediction.
// ----------------------------------------------------------------------------
module pair_grouping_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,  // first_id[15:0], second_id[31:16]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [55:0] m_tdata,  // leader_id, removed_id, group_index, started_group,
	                              // leader_conflict, table_full, reduced_count, zero pad
	output int          fails,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [pgt_pkg::ID_BITS-1:0]   id_t;
	typedef logic [pgt_pkg::GIDX_BITS-1:0] gidx_t;

	typedef struct packed {
		logic [4:0]           pad;
		logic [8:0]           reduced_count;
		logic                 table_full;
		logic                 leader_conflict;
		logic                 started_group;
		gidx_t                group_index;
		id_t                  removed_id;
		id_t                  leader_id;
	} pair_result_t;

	id_t                  member_id [pgt_pkg::MAX_MEMBERS];
	gidx_t                member_grp [pgt_pkg::MAX_MEMBERS];
	id_t                  leader_of [pgt_pkg::MAX_GROUPS];
	int                   n_members;
	int                   n_groups;
	pair_result_t         expected_results [$];

	// Find the lowest group that holds either id, then append, start a group or flag full.
	function automatic pair_result_t join_pair(id_t a, id_t b);
		pair_result_t r;
		int           best;
		bit           a_in_best;
		best = -1;
		a_in_best = 0;
		for (int i = 0; i < n_members; i++) begin
			if (member_id[i] == a || member_id[i] == b) begin
				if (best < 0 || int'(member_grp[i]) < best) begin
					best = int'(member_grp[i]);
					a_in_best = (member_id[i] == a);
				end else if (int'(member_grp[i]) == best && member_id[i] == a) begin
					a_in_best = 1;
				end
			end
		end
		r = '0;
		r.leader_id = a;
		r.removed_id = b;
		if (best >= 0) begin
			r.group_index = gidx_t'(best);
			r.leader_id = leader_of[best];
			if (a == r.leader_id)
				r.removed_id = b;
			else if (b == r.leader_id)
				r.removed_id = a;
			else
				r.leader_conflict = 1'b1;
			if (n_members < pgt_pkg::MAX_MEMBERS) begin
				member_id[n_members] = a_in_best ? b : a;
				member_grp[n_members] = gidx_t'(best);
				n_members++;
			end else begin
				r.table_full = 1'b1;
			end
		end else if (n_groups < pgt_pkg::MAX_GROUPS &&
		             n_members + 2 <= pgt_pkg::MAX_MEMBERS) begin
			r.group_index = gidx_t'(n_groups);
			leader_of[n_groups] = a;
			member_id[n_members] = a;
			member_grp[n_members] = gidx_t'(n_groups);
			member_id[n_members + 1] = b;
			member_grp[n_members + 1] = gidx_t'(n_groups);
			n_members += 2;
			n_groups++;
			r.started_group = 1'b1;
		end else begin
			r.table_full = 1'b1;
		end
		r.reduced_count = 9'(n_members - n_groups);
		return r;
	endfunction

	task automatic check_field(string what, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pair_result_t want;
		pair_result_t got;
		if (!arst_n) begin
			n_members = 0;
			n_groups = 0;
			expected_results.delete();
			fails = 0;
			pending = 0;
		end else begin
			// a result word can never belong to the pair taken in on the same edge
			if (m_tvalid && m_tready) begin
				got = pair_result_t'(m_tdata);
				if (expected_results.size() == 0) begin
					$display("%0t ns: unexpected result word, expected none, actual %h",
						$time, m_tdata);
					fails++;
				end else begin
					want = expected_results.pop_front();
					check_field("leader_id", want.leader_id, got.leader_id);
					check_field("removed_id", want.removed_id, got.removed_id);
					check_field("group_index", want.group_index, got.group_index);
					check_field("started_group", want.started_group, got.started_group);
					check_field("leader_conflict", want.leader_conflict, got.leader_conflict);
					check_field("table_full", want.table_full, got.table_full);
					check_field("reduced_count", want.reduced_count, got.reduced_count);
					check_field("pad", want.pad, got.pad);
				end
			end
			if (s_tvalid && s_tready)
				expected_results = {expected_results,
					join_pair(s_tdata[15:0], s_tdata[31:16])};
			pending = expected_results.size();
		end
	end

endmodule

// ===== tb/tb_pair_grouping_table.sv =====
// ----------------------------------------------------------------------------
// tb_pair_grouping_table
// Drives id pairs into the pair grouping table: a directed opening that walks
// leader, non-leader, conflict, shared-id and fresh-group cases, then random
// pairs drawn mostly from ids already seen so groups grow until the stores
// fill. Both ports idle at random; the checker scores every result word.
// ----------------------------------------------------------------------------
module tb_pair_grouping_table;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_PAIRS = 1500;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 300;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;

	int          fails;
	int          pending;
	int          pairs_sent = 0;
	int          results_seen = 0;
	int          stall_cycles = 0;
	bit          no_idle = 0;
	logic [15:0] seen_ids [$];

	pair_grouping_table DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	pair_grouping_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.fails    (fails),
		.pending  (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= arst_n && (no_idle || $urandom_range(0, 99) >= 24);
	end

	// Abort when neither port has moved a word for too long.
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			results_seen <= results_seen + 1;
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles == STALL_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic send_pair(logic [15:0] first_id, logic [15:0] second_id);
		while (!no_idle && $urandom_range(0, 99) < 24) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {second_id, first_id};
		do @(posedge clk); while (!s_tready);
		pairs_sent++;
		seen_ids = {seen_ids, first_id, second_id};
		if (seen_ids.size() > 512)
			void'(seen_ids.pop_front());
	endtask

	// Favor recent ids so pairs keep landing in live groups.
	function automatic logic [15:0] old_id();
		int last;
		last = seen_ids.size() - 1;
		if ($urandom_range(0, 1))
			return seen_ids[last - $urandom_range(0, (last < 31) ? last : 31)];
		return seen_ids[$urandom_range(0, last)];
	endfunction

	initial begin
		logic [15:0] a;
		logic [15:0] b;
		int          pick;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_pair(16'h0000, 16'hFFFF);  // start group 0
		send_pair(16'hFFFF, 16'h1234);  // hit on non-leader, neither is leader
		send_pair(16'h5555, 16'h0000);  // second id is leader
		send_pair(16'h0000, 16'h7777);  // first id is leader
		send_pair(16'h0000, 16'hFFFF);  // both already in group
		send_pair(16'hAAAA, 16'hAAAA);  // same id twice, fresh group
		send_pair(16'hAAAA, 16'hAAAA);
		send_pair(16'h8001, 16'h0001);
		send_pair(16'h0001, 16'h5555);  // ids split over two groups, lower wins
		send_pair(16'h1234, 16'hAAAA);
		send_pair(16'h00FF, 16'hFF00);
		send_pair(16'hFF00, 16'h00FF);
		send_pair(16'h7FFF, 16'h8000);
		send_pair(16'h8000, 16'h0000);

		for (int n = 0; n < RANDOM_PAIRS; n++) begin
			if (n == 300) begin
				// hold off until every result word is back
				s_tvalid <= 1'b0;
				@(posedge clk);
				while (results_seen != pairs_sent) @(posedge clk);
			end
			no_idle = (n >= 600 && n < 900);
			pick = $urandom_range(0, 99);
			a = 16'($urandom());
			b = 16'($urandom());
			if (pick < 35)
				a = old_id();
			else if (pick < 60)
				b = old_id();
			else if (pick < 85) begin
				a = old_id();
				b = old_id();
			end else if (pick < 92)
				b = a;
			send_pair(a, b);
		end
		s_tvalid <= 1'b0;

		while (results_seen != pairs_sent) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
